[src/affine_warp_nearest_fetch_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the affine warp fetch block
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_WARP_NEAREST_FETCH_MACROS_SVH
`define AFFINE_WARP_NEAREST_FETCH_MACROS_SVH

// Same-cycle implication.
`define AWNF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("awnf assertion failed");

// Next-cycle implication.
`define AWNF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("awnf assertion failed");

`endif

[src/awnf_pkg.sv]
// ----------------------------------------------------------------------------
// awnf_pkg
// Types, widths and reset values shared by the affine warp fetch modules.
// ----------------------------------------------------------------------------
package awnf_pkg;

   localparam int POS_W       = 10;
   localparam int PIX_W       = 24;
   localparam int COEF_W      = 24;
   localparam int OFF_W       = 29;
   localparam int SIZE_W      = 9;
   localparam int CSR_DATA_W  = 29;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = 35;
   localparam int SUM_W       = 36;
   localparam int FRAC_W      = 16;
   localparam int SRC_W       = SUM_W - FRAC_W;

   localparam int DEFAULT_MAX_ROWS = 256;
   localparam int DEFAULT_MAX_COLS = 256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [COEF_W-1:0] COEF_ONE   = COEF_W'(65536);
   localparam logic signed [COEF_W-1:0] COEF_ZERO  = '0;
   localparam logic signed [OFF_W-1:0]  OFF_ZERO   = '0;
   localparam logic [SIZE_W-1:0]        SIZE_RESET = SIZE_W'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_FROM_ROW = 3'd0,
      CSR_ROW_FROM_COL = 3'd1,
      CSR_ROW_OFFSET   = 3'd2,
      CSR_COL_FROM_ROW = 3'd3,
      CSR_COL_FROM_COL = 3'd4,
      CSR_COL_OFFSET   = 3'd5,
      CSR_SOURCE_ROWS  = 3'd6,
      CSR_SOURCE_COLS  = 3'd7
   } csr_index_type;

   typedef enum logic {
      ACTION_LOAD  = 1'b0,
      ACTION_FETCH = 1'b1
   } action_type;

   typedef struct packed {
      logic              action;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [PIX_W-1:0]  pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]  out_pixel;
      logic              hit;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[src/affine_warp_nearest_fetch.sv]
// ----------------------------------------------------------------------------
// affine_warp_nearest_fetch
// Nearest-neighbor inverse affine warp over a built-in source frame.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one beat per item: a load writes a pixel into the
//   source frame, a fetch maps an output row and column through the inverse
//   matrix and asks for the source pixel there. Every beat, load or fetch,
//   gives exactly one beat on the rsp channel, in order.
//   The csr port writes the matrix, offsets and frame size; write it only
//   while no beat is in flight.
//   On the way to rsp_valid, the multiply stage is loaded when a req beat
//   is accepted, the sum and bound check then enter the job queue, and the
//   frame memory access fills the output register, which drives rsp_valid.
//   Throughput is one beat per cycle while rsp_ready stays high, set by the
//   single-port frame memory taking one job a cycle.
//   When rsp_ready is low the output register holds its beat, the queue of
//   four jobs fills, and req_ready falls once the queue and multiply stage
//   are full. Reset loads the identity matrix and a full-size frame and
//   empties the pipeline; the frame contents are not cleared and a pixel must
//   be loaded before it is fetched.
// ----------------------------------------------------------------------------
`include "affine_warp_nearest_fetch_macros.svh"

module affine_warp_nearest_fetch #(
   parameter int MAX_ROWS = awnf_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = awnf_pkg::DEFAULT_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  awnf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output awnf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [awnf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [awnf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import awnf_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);

   typedef struct packed {
      logic              is_fetch;
      logic              wr_en;
      logic              hit;
      logic [ROW_W-1:0]  row_idx;
      logic [COL_W-1:0]  col_idx;
      logic [PIX_W-1:0]  pixel;
   } job_type;

   q_status_type q_status;
   logic         q_push, q_pop;
   job_type      push_job, head_job;

   awnf_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   awnf_queue #(
      .job_type (job_type)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   awnf_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `AWNF_ASSERT_NOW(a_no_push_full, q_push, !q_status.full)
   `AWNF_ASSERT_NOW(a_no_pop_empty, q_pop, !q_status.empty)
   `AWNF_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_data.hit, rsp_data.out_pixel == '0)
   `AWNF_ASSERT_NEXT(a_load_no_hit, q_pop && !head_job.is_fetch, !rsp_data.hit)

endmodule

[src/awnf_front.sv]
// ----------------------------------------------------------------------------
// awnf_front
// Holds the matrix registers, accepts beats, forms the products, then sums,
// truncates and bound-checks them into one job for the queue.
// ----------------------------------------------------------------------------
module awnf_front #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  awnf_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [awnf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [awnf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  awnf_pkg::q_status_type             q_status,
   output logic                               q_push,
   output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)+awnf_pkg::PIX_W+2:0] q_job
);
   import awnf_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);

   typedef struct packed {
      logic              is_fetch;
      logic              wr_en;
      logic              hit;
      logic [ROW_W-1:0]  row_idx;
      logic [COL_W-1:0]  col_idx;
      logic [PIX_W-1:0]  pixel;
   } job_type;

   logic signed [COEF_W-1:0] rr_ff, rc_ff, cr_ff, cc_ff;
   logic signed [OFF_W-1:0]  roff_ff, coff_ff;
   logic [SIZE_W-1:0]        rows_ff, cols_ff;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_action_ff;
   logic [POS_W-1:0]         s1_row_ff, s1_col_ff;
   logic [PIX_W-1:0]         s1_pixel_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_rc_ff, p_cr_ff, p_cc_ff;
   logic signed [PROD_W-1:0] p_rr_in, p_rc_in, p_cr_in, p_cc_in;

   logic                     accept, advance;
   logic signed [SUM_W-1:0]  sum_row, sum_col;
   logic [SRC_W-1:0]         src_row, src_col, lim_rows, lim_cols;
   logic [SRC_W-1:0]         ld_row, ld_col;
   logic                     hit_row, hit_col, ld_ok;
   job_type                  job;

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff   <= COEF_ONE;
         rc_ff   <= COEF_ZERO;
         roff_ff <= OFF_ZERO;
         cr_ff   <= COEF_ZERO;
         cc_ff   <= COEF_ONE;
         coff_ff <= OFF_ZERO;
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_FROM_ROW: rr_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_ROW_FROM_COL: rc_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_ROW_OFFSET:   roff_ff <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_COL_FROM_ROW: cr_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COL_FROM_COL: cc_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COL_OFFSET:   coff_ff <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_SOURCE_ROWS:  rows_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SOURCE_COLS:  cols_ff <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = s1_valid_ff && !q_status.full;
   assign req_ready = !s1_valid_ff || !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      p_rr_in = PROD_W'($signed({1'b0, req_data.row}) * rr_ff);
      p_rc_in = PROD_W'($signed({1'b0, req_data.col}) * rc_ff);
      p_cr_in = PROD_W'($signed({1'b0, req_data.row}) * cr_ff);
      p_cc_in = PROD_W'($signed({1'b0, req_data.col}) * cc_ff);
      s1_valid_in = accept || (s1_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_data.action;
         s1_row_ff    <= req_data.row;
         s1_col_ff    <= req_data.col;
         s1_pixel_ff  <= req_data.pixel;
         p_rr_ff      <= p_rr_in;
         p_rc_ff      <= p_rc_in;
         p_cr_ff      <= p_cr_in;
         p_cc_ff      <= p_cc_in;
      end
   end

   // A negative sum truncates to a row or column of zero or below, always a miss.
   always_comb begin
      sum_row  = SUM_W'(p_rr_ff) + SUM_W'(p_rc_ff) + SUM_W'(roff_ff);
      sum_col  = SUM_W'(p_cr_ff) + SUM_W'(p_cc_ff) + SUM_W'(coff_ff);
      src_row  = sum_row[FRAC_W +: SRC_W];
      src_col  = sum_col[FRAC_W +: SRC_W];
      lim_rows = (SRC_W'(rows_ff) > SRC_W'(MAX_ROWS)) ? SRC_W'(MAX_ROWS) : SRC_W'(rows_ff);
      lim_cols = (SRC_W'(cols_ff) > SRC_W'(MAX_COLS)) ? SRC_W'(MAX_COLS) : SRC_W'(cols_ff);
      hit_row  = !sum_row[SUM_W-1] && (src_row != '0) && (src_row < lim_rows);
      hit_col  = !sum_col[SUM_W-1] && (src_col != '0) && (src_col < lim_cols);
      ld_row   = SRC_W'(s1_row_ff);
      ld_col   = SRC_W'(s1_col_ff);
      ld_ok    = (ld_row < SRC_W'(MAX_ROWS)) && (ld_col < SRC_W'(MAX_COLS));

      job.pixel = s1_pixel_ff;
      if (s1_action_ff == ACTION_FETCH) begin
         job.is_fetch = 1'b1;
         job.wr_en    = 1'b0;
         job.hit      = hit_row && hit_col;
         job.row_idx  = src_row[ROW_W-1:0];
         job.col_idx  = src_col[COL_W-1:0];
      end else begin
         job.is_fetch = 1'b0;
         job.wr_en    = ld_ok;
         job.hit      = 1'b0;
         job.row_idx  = ld_row[ROW_W-1:0];
         job.col_idx  = ld_col[COL_W-1:0];
      end
   end

   assign q_push = advance;
   assign q_job  = job;

endmodule

[src/awnf_queue.sv]
// ----------------------------------------------------------------------------
// awnf_queue
// Short in-order queue of load and fetch jobs between the front and the back.
// ----------------------------------------------------------------------------
module awnf_queue #(
   parameter type job_type = logic
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  job_type                 push_job,
   input  logic                    pop,
   output job_type                 head_job,
   output awnf_pkg::q_status_type  status
);
   import awnf_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[src/awnf_back.sv]
// ----------------------------------------------------------------------------
// awnf_back
// Owns the source frame memory; writes loads, reads fetches and holds the
// result beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module awnf_back #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  awnf_pkg::q_status_type  q_status,
   input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)+awnf_pkg::PIX_W+2:0] q_job,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output awnf_pkg::rsp_type       rsp_data
);
   import awnf_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;

   typedef struct packed {
      logic              is_fetch;
      logic              wr_en;
      logic              hit;
      logic [ROW_W-1:0]  row_idx;
      logic [COL_W-1:0]  col_idx;
      logic [PIX_W-1:0]  pixel;
   } job_type;

   logic [PIX_W-1:0]  frame_mem [1 << ADDR_W];
   job_type           job;
   logic [ADDR_W-1:0] addr;
   logic              out_valid_ff;
   logic              hit_ff;
   logic [PIX_W-1:0]  rdata_ff;

   assign job   = q_job;
   assign addr  = {job.row_idx, job.col_idx};
   assign q_pop = !q_status.empty && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (q_pop && job.wr_en) begin
         frame_mem[addr] <= job.pixel;
      end
      if (q_pop && job.hit) begin
         rdata_ff <= frame_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
         hit_ff       <= job.hit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data.hit       = hit_ff;
   assign rsp_data.out_pixel = hit_ff ? rdata_ff : '0;

endmodule
